[sv/lcsl_pkg.sv]
`default_nettype none

package lcsl_pkg;

	localparam int WAYS_DEF = 8;
	localparam int TAG_BITS_DEF = 24;
	localparam int ACCESS_TAG_W = 24;
	localparam int WAYS_IN_USE_W = 4;
	localparam int WAYS_IN_USE_RST = 8;

	// Control shared by every cell of the recency stack
	typedef struct packed {
		logic step;   // an item is accepted this cycle
		logic flush;  // configuration write: invalidate the whole set
	} cell_ctrl_t;

endpackage

`default_nettype wire

[sv/lru_cache_set_lookup.sv]
`default_nettype none

// Channel   Handshake            Payload
// in        in_valid/in_ready    access_tag
// out       out_valid/out_ready  hit
// cfg       cfg_we               cfg_wdata (ways in use)
//
// One item per cycle unless stalled; the result appears in the cycle after acceptance.
// The set is a row of WAYS cells ordered by recency; on each item every cell
// from the top down to the hit position (or every active cell on a miss) takes its
// neighbour's entry, and the tag enters at the top. A single output register
// holds the result; in_ready drops only while it is full and out_ready is low.
// Reset and any configuration write invalidate every way.
module lru_cache_set_lookup #(
	parameter int WAYS     = lcsl_pkg::WAYS_DEF,
	parameter int TAG_BITS = lcsl_pkg::TAG_BITS_DEF
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  cfg_we,
	input  wire  [lcsl_pkg::WAYS_IN_USE_W-1:0]   cfg_wdata,
	input  wire                                  in_valid,
	output logic                                 in_ready,
	input  wire  [lcsl_pkg::ACCESS_TAG_W-1:0]    access_tag,
	output logic                                 out_valid,
	input  wire                                  out_ready,
	output logic                                 hit
);

	localparam int AW = $clog2(WAYS + 1);
	localparam int RST_ACTIVE = (lcsl_pkg::WAYS_IN_USE_RST > WAYS) ? WAYS
		: lcsl_pkg::WAYS_IN_USE_RST;

	logic [AW-1:0]       active_q;
	logic [AW-1:0]       active_nxt;
	logic                out_valid_q;
	logic                hit_q;
	logic                accept;
	lcsl_pkg::cell_ctrl_t ctrl;

	logic [lcsl_pkg::ACCESS_TAG_W+TAG_BITS-1:0] tag_ext;
	logic [TAG_BITS-1:0]                        tag_in;

	logic [TAG_BITS-1:0] chain_tag   [WAYS+1];
	logic                chain_valid [WAYS+1];
	logic                chain_found [WAYS+1];

	assign tag_ext = {{TAG_BITS{1'b0}}, access_tag};
	assign tag_in  = tag_ext[TAG_BITS-1:0];

	assign in_ready  = ~out_valid_q | out_ready;
	assign accept    = in_valid & in_ready;
	assign out_valid = out_valid_q;
	assign hit       = hit_q;

	always_comb begin
		ctrl.step  = accept;
		ctrl.flush = cfg_we;
	end

	// top of the chain: new entry is the access tag, marked valid
	assign chain_tag[0]   = tag_in;
	assign chain_valid[0] = 1'b1;
	assign chain_found[0] = 1'b0;

	for (genvar i = 0; i < WAYS; i++) begin : g_cell
		logic cell_active;
		assign cell_active = (32'(i) < 32'(active_q));
		lcsl_cell #(
			.TAG_BITS(TAG_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.active    (cell_active),
			.tag_in    (tag_in),
			.tag_prev  (chain_tag[i]),
			.valid_prev(chain_valid[i]),
			.found_prev(chain_found[i]),
			.tag_out   (chain_tag[i+1]),
			.valid_out (chain_valid[i+1]),
			.found_out (chain_found[i+1])
		);
	end

	// clamp the written value to 1..WAYS
	always_comb begin
		if (cfg_wdata == '0) begin
			active_nxt = AW'(1);
		end else if (32'(cfg_wdata) > 32'(WAYS)) begin
			active_nxt = AW'(WAYS);
		end else begin
			active_nxt = AW'(cfg_wdata);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= AW'(RST_ACTIVE);
		end else if (cfg_we) begin
			active_q <= active_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hit_q <= chain_found[WAYS];
		end
	end

endmodule

`default_nettype wire

[sv/lcsl_cell.sv]
`default_nettype none

// One entry of the recency stack. Position 0 is the most recent.
module lcsl_cell #(
	parameter int TAG_BITS = lcsl_pkg::TAG_BITS_DEF
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  lcsl_pkg::cell_ctrl_t     ctrl,
	input  wire                      active,
	input  wire  [TAG_BITS-1:0]      tag_in,
	input  wire  [TAG_BITS-1:0]      tag_prev,
	input  wire                      valid_prev,
	input  wire                      found_prev,
	output logic [TAG_BITS-1:0]      tag_out,
	output logic                     valid_out,
	output logic                     found_out
);

	logic [TAG_BITS-1:0] tag_q;
	logic                valid_q;
	logic                match;
	logic                upd;

	assign match     = valid_q & active & (tag_q == tag_in);
	assign found_out = found_prev | match;
	// take the neighbour's entry unless the hit lies above this position
	assign upd       = ctrl.step & active & ~found_prev;
	assign tag_out   = tag_q;
	assign valid_out = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.flush) begin
			valid_q <= 1'b0;
		end else if (upd) begin
			valid_q <= valid_prev;
		end
	end

	always_ff @(posedge clk) begin
		if (upd) begin
			tag_q <= tag_prev;
		end
	end

endmodule

`default_nettype wire
